// ===== rtl/core/urm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types and constants of the UID range set merger.
// ----------------------------------------------------------------------------
package urm_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int MAX_OUT      = 32;
	localparam int UID_W        = 32;
	localparam int ENT_W        = 2 * UID_W;

	localparam logic [1:0] KIND_INSERT  = 2'd0;
	localparam logic [1:0] KIND_READOUT = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;

	typedef struct packed {
		logic             below;
		logic             overlap;
		logic [UID_W-1:0] new_lo;
		logic [UID_W-1:0] new_hi;
	} cmp_res_t;

endpackage

// ===== rtl/core/uid_range_set_merger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uid_range_set_merger
// Sorted table of disjoint UID ranges with union insert, readout and clear.
// ----------------------------------------------------------------------------
// input words: tuser carries the kind (insert, readout, clear), tdata the
// range bounds, tlast the end of one record's range list. Output words carry
// a range in tdata, the last-of-readout mark in tlast, empty and overflow
// flags in tuser.
// an insert walks the table once through the shared compare unit, copying
// it into the spare bank with the new range merged in; the acknowledgement
// is loaded as the banks swap, and the block turns idle at that same edge.
// an overflowing insert leaves the table as it was.
// a readout gives one word per cycle while the receiver takes them, from
// the registered RAM read port, at most 32 words; an empty table gives a
// single flagged word. a clear gives no word.
// s_axis_tready is high only while the block is idle; one item at a time.
// a stalled receiver holds the output register, and the sequencer waits.
// reset empties the table and the output register; RAM needs no clearing.
// ----------------------------------------------------------------------------
module uid_range_set_merger import urm_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // range_low, range_high
	input  logic [1:0]  s_axis_tuser,   // kind
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // out_low, out_high
	output logic [1:0]  m_axis_tuser,   // empty_res, overflow
	output logic        m_axis_tlast
);

	localparam int AW     = $clog2(CAPACITY);
	localparam int CW     = $clog2(CAPACITY + 2);
	localparam int RD_MAX = (CAPACITY < MAX_OUT) ? CAPACITY : MAX_OUT;
	localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
	localparam logic [CW-1:0] RD_MAX_C = CW'(RD_MAX);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS,
		ST_INS_END,
		ST_RD
	} state_t;

	state_t           state_q;
	logic             bank_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    wcnt_q;
	logic             placed_q;
	logic [UID_W-1:0] lo_q;
	logic [UID_W-1:0] hi_q;
	logic             be_q;
	logic             out_valid_q;
	logic [UID_W-1:0] out_low_q;
	logic [UID_W-1:0] out_high_q;
	logic             out_last_q;
	logic             out_empty_q;
	logic             out_ovf_q;

	logic [CW-1:0]    idx_nxt;
	logic             ram_we;
	logic             put_new;
	logic [ENT_W-1:0] ram_wdata;
	logic             wr0;
	logic             wr1;
	logic [ENT_W-1:0] rd0;
	logic [ENT_W-1:0] rd1;
	logic [ENT_W-1:0] rdata;
	logic             out_free;
	logic             out_load;
	logic [CW-1:0]    rd_lim;
	logic             rd_last;
	logic [UID_W-1:0] in_lo;
	logic [UID_W-1:0] in_hi;
	cmp_res_t         cmp;

	assign in_lo = s_axis_tdata[UID_W-1:0];
	assign in_hi = s_axis_tdata[ENT_W-1:UID_W];

	assign rdata    = bank_q ? rd1 : rd0;
	assign out_free = !out_valid_q || m_axis_tready;
	assign out_load = out_free && (state_q == ST_INS_END || state_q == ST_RD);
	assign rd_lim   = (cnt_q > RD_MAX_C) ? RD_MAX_C : cnt_q;
	assign rd_last  = (idx_q + CW'(1)) == rd_lim;

	assign s_axis_tready = (state_q == ST_IDLE);

	urm_cmp u_cmp (
		.ent (rdata),
		.lo  (lo_q),
		.hi  (hi_q),
		.res (cmp)
	);

	always_comb begin
		idx_nxt   = idx_q;
		ram_we    = 1'b0;
		put_new   = 1'b0;
		ram_wdata = rdata;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					idx_nxt = '0;
				end
			end
			ST_INS: begin
				if (idx_q == cnt_q) begin
					if (!placed_q) begin
						ram_we  = 1'b1;
						put_new = 1'b1;
					end
				end else if (cmp.below) begin
					ram_we  = 1'b1;
					idx_nxt = idx_q + CW'(1);
				end else if (cmp.overlap) begin
					idx_nxt = idx_q + CW'(1);
				end else if (!placed_q) begin
					ram_we  = 1'b1;
					put_new = 1'b1;
				end else begin
					ram_we  = 1'b1;
					idx_nxt = idx_q + CW'(1);
				end
			end
			ST_RD: begin
				if (cnt_q != '0 && out_free) begin
					idx_nxt = idx_q + CW'(1);
				end
			end
			default: begin
			end
		endcase
		if (put_new) begin
			ram_wdata = {hi_q, lo_q};
		end
	end

	// writes past the last slot are dropped; the count then flags overflow
	assign wr0 = ram_we && (wcnt_q < CAP_C) && bank_q;
	assign wr1 = ram_we && (wcnt_q < CAP_C) && !bank_q;

	urm_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY)
	) u_ram0 (
		.clk   (clk),
		.we    (wr0),
		.waddr (wcnt_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (idx_nxt[AW-1:0]),
		.rdata (rd0)
	);

	urm_ram #(
		.WIDTH (ENT_W),
		.DEPTH (CAPACITY)
	) u_ram1 (
		.clk   (clk),
		.we    (wr1),
		.waddr (wcnt_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (idx_nxt[AW-1:0]),
		.rdata (rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bank_q      <= 1'b0;
			cnt_q       <= '0;
			idx_q       <= '0;
			wcnt_q      <= '0;
			placed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			idx_q <= idx_nxt;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						case (s_axis_tuser)
							KIND_INSERT: begin
								lo_q     <= (in_lo > in_hi) ? in_hi : in_lo;
								hi_q     <= (in_lo > in_hi) ? in_lo : in_hi;
								be_q     <= s_axis_tlast;
								wcnt_q   <= '0;
								placed_q <= 1'b0;
								state_q  <= ST_INS;
							end
							KIND_READOUT: begin
								state_q <= ST_RD;
							end
							KIND_CLEAR: begin
								cnt_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_INS: begin
					if (ram_we) begin
						wcnt_q <= wcnt_q + CW'(1);
					end
					if (put_new) begin
						placed_q <= 1'b1;
					end
					if (idx_q == cnt_q) begin
						state_q <= ST_INS_END;
					end else if (!cmp.below && cmp.overlap) begin
						lo_q <= cmp.new_lo;
						hi_q <= cmp.new_hi;
					end
				end
				ST_INS_END: begin
					if (out_free) begin
						out_low_q   <= '0;
						out_high_q  <= '0;
						out_last_q  <= be_q;
						out_empty_q <= 1'b0;
						out_ovf_q   <= wcnt_q > CAP_C;
						if (wcnt_q <= CAP_C) begin
							bank_q <= ~bank_q;
							cnt_q  <= wcnt_q;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					if (out_free) begin
						out_ovf_q <= 1'b0;
						if (cnt_q == '0) begin
							out_low_q   <= '0;
							out_high_q  <= '0;
							out_last_q  <= 1'b1;
							out_empty_q <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							out_low_q   <= rdata[UID_W-1:0];
							out_high_q  <= rdata[ENT_W-1:UID_W];
							out_last_q  <= rd_last;
							out_empty_q <= 1'b0;
							if (rd_last) begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_high_q, out_low_q};
	assign m_axis_tuser  = {out_ovf_q, out_empty_q};
	assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/urm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module urm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/urm_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_cmp
// Shared range compare unit: position of a stored range against the pending
// range, and the union of both.
// ----------------------------------------------------------------------------
module urm_cmp import urm_pkg::*; (
	input  logic [ENT_W-1:0] ent,
	input  logic [UID_W-1:0] lo,
	input  logic [UID_W-1:0] hi,
	output cmp_res_t         res
);

	logic [UID_W-1:0] ent_lo;
	logic [UID_W-1:0] ent_hi;

	assign ent_lo = ent[UID_W-1:0];
	assign ent_hi = ent[ENT_W-1:UID_W];

	always_comb begin
		// 33-bit sums so touching ranges never wrap
		res.below   = ({1'b0, ent_hi} + 33'd1) < {1'b0, lo};
		res.overlap = {1'b0, ent_lo} <= ({1'b0, hi} + 33'd1);
		res.new_lo  = (ent_lo < lo) ? ent_lo : lo;
		res.new_hi  = (ent_hi > hi) ? ent_hi : hi;
	end

endmodule

// ===== rtl/core/urm_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_chk
// Port-level checks of the UID range set merger, bound to the top level.
// ----------------------------------------------------------------------------
module urm_chk import urm_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [63:0] s_axis_tdata,
	input logic [1:0]  s_axis_tuser,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser,
	input logic        m_axis_tlast
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// insert and readout close the input once they are accepted
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready
			&& (s_axis_tuser == KIND_INSERT || s_axis_tuser == KIND_READOUT)
			|=> !s_axis_tready)
		else $error("input accepted while busy");

	// empty readout word is zero and ends the readout
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 64'd0
			&& !m_axis_tuser[1])
		else $error("malformed empty readout word");

	// overflow only on an acknowledgement
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 64'd0)
		else $error("overflow flag on a range word");

endmodule

bind uid_range_set_merger urm_chk u_urm_chk (.*);

// ===== test/tb_uid_range_set_merger.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_uid_range_set_merger
// Self-checking bench for the UID range set merger.
// ----------------------------------------------------------------------------
// a short table of directed words (empty table, extreme bounds, zero bound,
// reversed bounds, adjacent and spanning merges, unused kind, clear) comes
// first, then random phases with sender gaps, receiver stalls and one long
// receiver hold-off. one phase fills the table past capacity. every output
// word is compared with a behavioral copy of the range table or a directed row's word.
// ----------------------------------------------------------------------------
module tb_uid_range_set_merger;
	import urm_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
		logic        last;
		logic        empty;
		logic        ovf;
	} out_word_t;

	typedef struct packed {
		logic [31:0] lo;
		logic [31:0] hi;
	} uid_span_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] lo;
		logic [31:0] hi;
		logic        be;
		logic        typed;
		out_word_t   want;
	} stim_row_t;

	localparam out_word_t NO_WORD    = '0;
	localparam out_word_t ACK_PLAIN  = '{lo: '0, hi: '0, last: 1'b0, empty: 1'b0, ovf: 1'b0};
	localparam out_word_t ACK_LAST   = '{lo: '0, hi: '0, last: 1'b1, empty: 1'b0, ovf: 1'b0};
	localparam out_word_t EMPTY_WORD = '{lo: '0, hi: '0, last: 1'b1, empty: 1'b1, ovf: 1'b0};
	localparam out_word_t FULL_SPAN  = '{lo: '0, hi: '1, last: 1'b1, empty: 1'b0, ovf: 1'b0};
	localparam int        DIR_ROWS   = 21;

	localparam stim_row_t dir_rows [DIR_ROWS] = '{
		'{KIND_READOUT, 32'd0,          32'd0,          1'b0, 1'b1, EMPTY_WORD},
		'{KIND_INSERT,  32'd1,          32'd1,          1'b0, 1'b1, ACK_PLAIN},
		'{KIND_INSERT,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 1'b1, ACK_LAST},
		'{KIND_INSERT,  32'd100,        32'd10,         1'b0, 1'b0, NO_WORD},
		'{KIND_INSERT,  32'd0,          32'd0,          1'b1, 1'b0, NO_WORD},
		'{KIND_INSERT,  32'd101,        32'd200,        1'b0, 1'b0, NO_WORD},
		'{KIND_INSERT,  32'd300,        32'd400,        1'b0, 1'b0, NO_WORD},
		'{KIND_INSERT,  32'd500,        32'd600,        1'b1, 1'b0, NO_WORD},
		'{KIND_INSERT,  32'd402,        32'd498,        1'b0, 1'b0, NO_WORD},
		'{KIND_READOUT, 32'd0,          32'd0,          1'b0, 1'b0, NO_WORD},
		'{KIND_INSERT,  32'd401,        32'd499,        1'b1, 1'b0, NO_WORD},
		'{KIND_INSERT,  32'hFFFF_FFF0,  32'hFFFF_FFFE,  1'b0, 1'b0, NO_WORD},
		'{KIND_READOUT, 32'd0,          32'd0,          1'b0, 1'b0, NO_WORD},
		'{KIND_UNUSED,  32'hA5A5_5A5A,  32'h5A5A_A5A5,  1'b1, 1'b0, NO_WORD},
		'{KIND_READOUT, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1, 1'b0, NO_WORD},
		'{KIND_INSERT,  32'hFFFF_FFFF,  32'd0,          1'b1, 1'b1, ACK_LAST},
		'{KIND_READOUT, 32'd0,          32'd0,          1'b0, 1'b1, FULL_SPAN},
		'{KIND_CLEAR,   32'd0,          32'd0,          1'b0, 1'b0, NO_WORD},
		'{KIND_READOUT, 32'd0,          32'd0,          1'b0, 1'b1, EMPTY_WORD},
		'{KIND_INSERT,  32'd7,          32'd5,          1'b0, 1'b1, ACK_PLAIN},
		'{KIND_READOUT, 32'd0,          32'd0,          1'b0, 1'b0, NO_WORD}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // range_low, range_high
	logic [1:0]  s_axis_tuser = '0;   // kind
	logic        s_axis_tlast = 1'b0; // batch_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // out_low, out_high
	logic [1:0]  m_axis_tuser;        // empty_res, overflow
	logic        m_axis_tlast;

	uid_span_t   span_tab [CAPACITY_DEF];
	int          span_cnt = 0;
	out_word_t   fresh_words [$];
	out_word_t   awaited_words [$];

	int          fail_cnt = 0;
	int          words_in = 0;
	int          words_out = 0;
	int          ovf_acks = 0;
	int          deepest = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_on = 1'b0;
	event        hold_go;

	uid_range_set_merger dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400_000;
		$display("uid_range_set_merger: mismatch");
		$finish;
	end

	// long receiver hold-off, counted in cycles
	initial begin : hold_side
		@(hold_go);
		hold_on = 1'b1;
		repeat (300) @(posedge clk);
		hold_on = 1'b0;
	end

	// applies one accepted word to the table copy, leaves its output words in fresh_words
	function automatic void predict_words(input logic [1:0] kind, input logic [31:0] lo_in,
			input logic [31:0] hi_in, input logic be);
		logic [32:0] lo, hi;
		int          f, j, gone, n;
		out_word_t   w;
		fresh_words = {};
		w = NO_WORD;
		case (kind)
			KIND_INSERT: begin
				lo = (lo_in > hi_in) ? {1'b0, hi_in} : {1'b0, lo_in};
				hi = (lo_in > hi_in) ? {1'b0, lo_in} : {1'b0, hi_in};
				w.last = be;
				f = 0;
				while (f < span_cnt && 33'(span_tab[f].hi) + 33'd1 < lo)
					f++;
				j = f;
				while (j < span_cnt && 33'(span_tab[j].lo) <= hi + 33'd1) begin
					if (33'(span_tab[j].lo) < lo)
						lo = {1'b0, span_tab[j].lo};
					if (33'(span_tab[j].hi) > hi)
						hi = {1'b0, span_tab[j].hi};
					j++;
				end
				if (j > f) begin
					gone = j - f - 1;
					span_tab[f] = '{lo: lo[31:0], hi: hi[31:0]};
					for (int k = j; k < span_cnt; k++)
						span_tab[k - gone] = span_tab[k];
					span_cnt -= gone;
				end else if (span_cnt >= CAPACITY_DEF) begin
					w.ovf = 1'b1;
				end else begin
					for (int k = span_cnt; k > f; k--)
						span_tab[k] = span_tab[k - 1];
					span_tab[f] = '{lo: lo[31:0], hi: hi[31:0]};
					span_cnt++;
				end
				fresh_words.push_back(w);
			end
			KIND_READOUT: begin
				if (span_cnt == 0) begin
					fresh_words.push_back(EMPTY_WORD);
				end else begin
					n = (span_cnt > MAX_OUT) ? MAX_OUT : span_cnt;
					for (int i = 0; i < n; i++) begin
						w.lo = span_tab[i].lo;
						w.hi = span_tab[i].hi;
						w.last = (i == n - 1);
						fresh_words.push_back(w);
					end
				end
			end
			KIND_CLEAR: begin
				span_cnt = 0;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic send_word(input logic [1:0] kind, input logic [31:0] lo, input logic [31:0] hi,
			input logic be, input logic typed, input out_word_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {hi, lo};
		s_axis_tuser <= kind;
		s_axis_tlast <= be;
		do @(posedge clk); while (!s_axis_tready);
		predict_words(kind, lo, hi, be);
		if (typed)
			awaited_words.push_back(want);
		else
			foreach (fresh_words[i])
				awaited_words.push_back(fresh_words[i]);
		words_in++;
		if (span_cnt > deepest)
			deepest = span_cnt;
	endtask

	task automatic random_batch(input int count);
		int          pick;
		logic [31:0] lo, hi;
		logic [1:0]  kind;
		repeat (count) begin
			pick = $urandom_range(99);
			lo = $urandom;
			hi = $urandom;
			kind = KIND_INSERT;
			if (pick < 40) begin
				// dense window so neighbors touch and merge often
				lo = $urandom_range(1023);
				hi = lo + $urandom_range(15);
			end else if (pick < 60) begin
				hi = lo + $urandom_range(255);
				if (hi < lo)
					hi = '1;
			end else if (pick < 72) begin
			end else if (pick < 86) begin
				kind = KIND_READOUT;
			end else if (pick < 93) begin
				kind = KIND_CLEAR;
			end else begin
				kind = KIND_UNUSED;
			end
			if (kind == KIND_INSERT && $urandom_range(3) == 0)
				{lo, hi} = {hi, lo};
			send_word(kind, lo, hi, 1'($urandom_range(1)), 1'b0, NO_WORD);
		end
	endtask

	always @(posedge clk) begin : rx_side
		out_word_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.lo = m_axis_tdata[31:0];
			got.hi = m_axis_tdata[63:32];
			got.last = m_axis_tlast;
			got.empty = m_axis_tuser[0];
			got.ovf = m_axis_tuser[1];
			words_out++;
			if (got.ovf)
				ovf_acks++;
			if (awaited_words.size() == 0) begin
				$error("unexpected output word, tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
				fail_cnt++;
			end else begin
				want = awaited_words.pop_front();
				if (got.lo !== want.lo) begin
					$error("out_low: expected %h, got %h", want.lo, got.lo);
					fail_cnt++;
				end
				if (got.hi !== want.hi) begin
					$error("out_high: expected %h, got %h", want.hi, got.hi);
					fail_cnt++;
				end
				if (got.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, got.last);
					fail_cnt++;
				end
				if (got.empty !== want.empty) begin
					$error("empty_res: expected %b, got %b", want.empty, got.empty);
					fail_cnt++;
				end
				if (got.ovf !== want.ovf) begin
					$error("overflow: expected %b, got %b", want.ovf, got.ovf);
					fail_cnt++;
				end
			end
		end
		if (hold_on) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		int          order [34];
		int          j, tmp;
		logic [31:0] base, lo;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].kind, dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].be,
				dir_rows[i].typed, dir_rows[i].want);

		// long receiver hold-off while words keep coming
		-> hold_go;
		random_batch(10);

		send_idle_pct = 54;
		random_batch(10);

		send_idle_pct = 0;
		recv_stall_pct = 54;
		random_batch(10);

		send_idle_pct = 20;
		recv_stall_pct = 20;
		// fill past capacity in shuffled order, isolated ranges
		send_word(KIND_CLEAR, '0, '0, 1'b0, 1'b0, NO_WORD);
		base = $urandom_range(32'hFFFF_0000, 32'd1000);
		foreach (order[i])
			order[i] = i;
		for (int i = 33; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[i]) begin
			lo = base + 32'(order[i] * 64);
			send_word(KIND_INSERT, lo, lo + $urandom_range(40), 1'($urandom_range(1)), 1'b0,
				NO_WORD);
		end
		lo = base + 32'(order[0] * 64);
		send_word(KIND_INSERT, lo + 32'd60, lo, 1'b1, 1'b0, NO_WORD);
		send_word(KIND_READOUT, '0, '0, 1'b0, 1'b0, NO_WORD);
		lo = base + 32'($urandom_range(30) * 64);
		send_word(KIND_INSERT, lo, lo + 32'd64, 1'b0, 1'b0, NO_WORD);
		send_word(KIND_INSERT, base - 32'd500, base - 32'd400, 1'b1, 1'b0, NO_WORD);
		send_word(KIND_READOUT, '0, '0, 1'b0, 1'b0, NO_WORD);
		random_batch(10);

		s_axis_tvalid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d input words accepted, %0d output words checked", words_in, words_out);
		$display("%0d overflow acks, table reached %0d of %0d entries", ovf_acks, deepest,
			CAPACITY_DEF);
		if (fail_cnt == 0)
			$display("uid_range_set_merger: match");
		else
			$display("uid_range_set_merger: mismatch");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/urm_pkg.sv
rtl/core/urm_ram.sv
rtl/core/urm_cmp.sv
rtl/core/uid_range_set_merger.sv
rtl/core/urm_chk.sv
test/tb_uid_range_set_merger.sv
